// ----- src/ove_pkg.sv -----
`timescale 1ns / 1ps
package ove_pkg;

  localparam int SQRT_STAGES = 16;
  localparam int BACK_STAGES = 11;

  localparam logic [15:0] OW_RESET = 16'd1311;
  localparam logic [15:0] VO_RESET = 16'd33;
  localparam logic [16:0] TANH_ONE = 17'd65536;

  typedef enum logic [2:0] {
    CFG_CAM_X       = 3'd0,
    CFG_CAM_Y       = 3'd1,
    CFG_CAM_Z       = 3'd2,
    CFG_OUTLINE_W   = 3'd3,
    CFG_VIEW_OFFSET = 3'd4
  } ove_cfg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
  } ove_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } ove_out_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0]       nneg;
    logic [2:0][15:0] nmag;
    logic [2:0][32:0] v;
    logic [2:0]       vneg;
    logic [2:0][32:0] m;
    logic             k;
    logic [2:0][63:0] sq;
    logic [2:0][31:0] nw;
    logic [2:0][48:0] vm;
    logic [63:0]      rad;
    logic [33:0]      srem;
    logic [31:0]      root;
    logic [32:0]      len;
    logic             tsat;
    logic [16:0]      tlo;
    logic [29:0]      tprod;
    logic [16:0]      th;
    logic [2:0][48:0] nm;
    logic [2:0][19:0] nt;
    logic [2:0][17:0] dn;
    logic [2:0][32:0] drem;
    logic [2:0][17:0] dq;
  } ove_pipe_t;

  function automatic logic [16:0] ove_tanh(input logic [5:0] idx);
    logic [16:0] t;
    case (idx)
      6'd0:    t = 17'd0;
      6'd1:    t = 17'd16051;
      6'd2:    t = 17'd30285;
      6'd3:    t = 17'd41625;
      6'd4:    t = 17'd49912;
      6'd5:    t = 17'd55593;
      6'd6:    t = 17'd59320;
      6'd7:    t = 17'd61694;
      6'd8:    t = 17'd63178;
      6'd9:    t = 17'd64096;
      6'd10:   t = 17'd64659;
      6'd11:   t = 17'd65002;
      6'd12:   t = 17'd65212;
      6'd13:   t = 17'd65339;
      6'd14:   t = 17'd65417;
      6'd15:   t = 17'd65464;
      6'd16:   t = 17'd65492;
      6'd17:   t = 17'd65509;
      6'd18:   t = 17'd65520;
      6'd19:   t = 17'd65526;
      6'd20:   t = 17'd65530;
      6'd21:   t = 17'd65532;
      6'd22:   t = 17'd65534;
      6'd23:   t = 17'd65535;
      6'd24:   t = 17'd65535;
      default: t = TANH_ONE;
    endcase
    return t;
  endfunction

endpackage

// ----- src/ove_front.sv -----
`timescale 1ns / 1ps
module ove_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               i_valid,
  input  ove_pkg::ove_in_t   i_data,
  input  logic [31:0]        cam_x,
  input  logic [31:0]        cam_y,
  input  logic [31:0]        cam_z,
  input  logic [15:0]        ow,
  input  logic [15:0]        vo,
  output logic               o_valid,
  output ove_pkg::ove_pipe_t o_data
);

  ove_pkg::ove_pipe_t s1_r, s2_r, s3_r, s4_r;
  ove_pkg::ove_pipe_t s1_nxt, s2_nxt, s3_nxt, s4_nxt;
  logic [3:0]         vld_r;

  // view vector and normal magnitude
  always_comb begin
    logic [2:0][31:0] pp;
    logic [2:0][31:0] cc;
    logic [2:0][15:0] nn;
    pp = {i_data.pos_z, i_data.pos_y, i_data.pos_x};
    cc = {cam_z, cam_y, cam_x};
    nn = {i_data.nrm_z, i_data.nrm_y, i_data.nrm_x};
    s1_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      s1_nxt.p[a]    = pp[a];
      s1_nxt.nneg[a] = nn[a][15];
      s1_nxt.nmag[a] = nn[a][15] ? 16'(~nn[a] + 16'd1) : nn[a];
      s1_nxt.v[a]    = {pp[a][31], pp[a]} - {cc[a][31], cc[a]};
    end
  end

  always_comb begin
    s2_nxt   = s1_r;
    s2_nxt.k = 1'b0;
    for (int a = 0; a < 3; a++) begin
      s2_nxt.vneg[a] = s1_r.v[a][32];
      s2_nxt.m[a]    = s1_r.v[a][32] ? 33'(~s1_r.v[a] + 33'd1) : s1_r.v[a];
      if (s2_nxt.m[a][32] || s2_nxt.m[a][31]) begin
        s2_nxt.k = 1'b1;
      end
    end
  end

  always_comb begin
    logic [31:0] q;
    s3_nxt = s2_r;
    q      = '0;
    for (int a = 0; a < 3; a++) begin
      q              = s2_r.k ? s2_r.m[a][32:1] : s2_r.m[a][31:0];
      s3_nxt.sq[a]   = q * q;
      s3_nxt.nw[a]   = s2_r.nmag[a] * ow;
      s3_nxt.vm[a]   = s2_r.m[a] * vo;
    end
  end

  always_comb begin
    s4_nxt      = s3_r;
    s4_nxt.rad  = s3_r.sq[0] + s3_r.sq[1] + s3_r.sq[2];
    s4_nxt.srem = '0;
    s4_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign o_valid = vld_r[3];
  assign o_data  = s4_r;

endmodule

// ----- src/ove_sqrt.sv -----
`timescale 1ns / 1ps
module ove_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               i_valid,
  input  ove_pkg::ove_pipe_t i_data,
  output logic               o_valid,
  output ove_pkg::ove_pipe_t o_data
);

  localparam int N = ove_pkg::SQRT_STAGES;

  ove_pkg::ove_pipe_t st_r [N];
  ove_pkg::ove_pipe_t st_nxt [N];
  logic [N-1:0]       vld_r;

  // one result bit of the integer root
  function automatic ove_pkg::ove_pipe_t root_bit(input ove_pkg::ove_pipe_t s);
    ove_pkg::ove_pipe_t r;
    logic [35:0]        rem_t;
    logic [35:0]        trial;
    r     = s;
    rem_t = {s.srem, s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    if (rem_t >= trial) begin
      r.srem = 34'(rem_t - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.srem = 34'(rem_t);
      r.root = {s.root[30:0], 1'b0};
    end
    r.rad = {s.rad[61:0], 2'b00};
    return r;
  endfunction

  always_comb begin
    st_nxt[0] = root_bit(root_bit(i_data));
    for (int j = 1; j < N; j++) begin
      st_nxt[j] = root_bit(root_bit(st_r[j-1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign o_valid = vld_r[N-1];
  assign o_data  = st_r[N-1];

endmodule

// ----- src/ove_back.sv -----
`timescale 1ns / 1ps
module ove_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               i_valid,
  input  ove_pkg::ove_pipe_t i_data,
  output logic               o_valid,
  output ove_pkg::ove_out_t  o_data
);

  localparam int N = ove_pkg::BACK_STAGES;

  ove_pkg::ove_pipe_t st_r [N];
  ove_pkg::ove_pipe_t st_nxt [N];
  logic [N-1:0]       vld_r;

  function automatic ove_pkg::ove_pipe_t div_bit(input ove_pkg::ove_pipe_t s);
    ove_pkg::ove_pipe_t r;
    logic [33:0]        rr;
    r  = s;
    rr = '0;
    for (int a = 0; a < 3; a++) begin
      rr = {s.drem[a], s.dn[a][17]};
      if (rr >= {1'b0, s.len}) begin
        rr       = rr - {1'b0, s.len};
        r.dq[a]  = {s.dq[a][16:0], 1'b1};
      end else begin
        r.dq[a]  = {s.dq[a][16:0], 1'b0};
      end
      r.drem[a] = rr[32:0];
      r.dn[a]   = {s.dn[a][16:0], 1'b0};
    end
    return r;
  endfunction

  function automatic ove_pkg::ove_pipe_t back_step(input ove_pkg::ove_pipe_t s,
                                                    input int j);
    ove_pkg::ove_pipe_t r;
    logic [49:0]        num;
    logic [15:0]        diff;
    r    = s;
    num  = '0;
    diff = '0;
    if (j == 0) begin
      r.len = s.k ? {s.root, 1'b0} : {1'b0, s.root};
    end else if (j == 1) begin
      r.tsat  = |s.len[32:19];
      r.tlo   = ove_pkg::ove_tanh({1'b0, s.len[18:14]});
      diff    = 16'(ove_pkg::ove_tanh(6'({1'b0, s.len[18:14]}) + 6'd1) - r.tlo);
      r.tprod = diff * s.len[13:0];
      for (int a = 0; a < 3; a++) begin
        num       = {1'b0, s.vm[a]} + {18'd0, s.len[32:1]};
        r.drem[a] = {1'b0, num[49:18]};
        r.dn[a]   = num[17:0];
        r.dq[a]   = '0;
      end
    end else begin
      r = div_bit(div_bit(s));
      if (j == 2) begin
        r.th = s.tsat ? ove_pkg::TANH_ONE : s.tlo + 17'(s.tprod[29:14]);
      end else if (j == 3) begin
        for (int a = 0; a < 3; a++) begin
          r.nm[a] = s.nw[a] * s.th;
        end
      end else if (j == 4) begin
        for (int a = 0; a < 3; a++) begin
          r.nt[a] = 20'((s.nm[a] + 49'h0_0000_2000_0000) >> 30);
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    st_nxt[0] = back_step(i_data, 0);
    for (int j = 1; j < N; j++) begin
      st_nxt[j] = back_step(st_r[j-1], j);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  // final sum and saturation
  always_comb begin
    ove_pkg::ove_pipe_t s;
    logic signed [33:0] sum;
    logic signed [33:0] ntv;
    logic signed [33:0] vtv;
    logic [2:0][31:0]   res;
    s   = st_r[N-1];
    sum = '0;
    ntv = '0;
    vtv = '0;
    res = '0;
    for (int a = 0; a < 3; a++) begin
      ntv = s.nneg[a] ? -$signed({14'd0, s.nt[a]}) : $signed({14'd0, s.nt[a]});
      if (s.len == '0) begin
        vtv = '0;
      end else begin
        vtv = s.vneg[a] ? -$signed({16'd0, s.dq[a]}) : $signed({16'd0, s.dq[a]});
      end
      sum = $signed({{2{s.p[a][31]}}, s.p[a]}) + ntv + vtv;
      if (sum > 34'sh0_7FFF_FFFF) begin
        res[a] = 32'h7FFF_FFFF;
      end else if (sum < -34'sh0_8000_0000) begin
        res[a] = 32'h8000_0000;
      end else begin
        res[a] = sum[31:0];
      end
    end
    o_data.out_x = res[0];
    o_data.out_y = res[1];
    o_data.out_z = res[2];
  end

  assign o_valid = vld_r[N-1];

endmodule

// ----- src/outline_vertex_extrude.sv -----
`timescale 1ns / 1ps
// pipeline from input transaction to output transaction: 4 front, 16 square root,
// 11 tanh/multiply/divide stages and the output register
// throughput: one vertex per cycle; a stalled output fills a one-entry skid register,
// after which in_stall holds the whole pipeline until it drains
// reset: synchronous active low rst_n clears all valid bits, camera to 0,
// outline width to 1311 and view offset to 33
module outline_vertex_extrude (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ove_pkg::ove_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ove_pkg::ove_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  logic [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [15:0] ow_r, vo_r;

  logic               en;
  logic               f_valid, s_valid, b_valid;
  ove_pkg::ove_pipe_t f_data, s_data;
  ove_pkg::ove_out_t  b_data;

  logic              out_valid_r, skid_valid_r;
  ove_pkg::ove_out_t out_data_r, skid_data_r;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      ow_r    <= ove_pkg::OW_RESET;
      vo_r    <= ove_pkg::VO_RESET;
    end else if (cfg_we) begin
      unique case (ove_pkg::ove_cfg_e'(cfg_addr))
        ove_pkg::CFG_CAM_X:       cam_x_r <= cfg_wdata;
        ove_pkg::CFG_CAM_Y:       cam_y_r <= cfg_wdata;
        ove_pkg::CFG_CAM_Z:       cam_z_r <= cfg_wdata;
        ove_pkg::CFG_OUTLINE_W:   ow_r    <= cfg_wdata[15:0];
        ove_pkg::CFG_VIEW_OFFSET: vo_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign pop      = out_valid_r && !out_stall;

  ove_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (in_valid),
    .i_data  (in_data),
    .cam_x   (cam_x_r),
    .cam_y   (cam_y_r),
    .cam_z   (cam_z_r),
    .ow      (ow_r),
    .vo      (vo_r),
    .o_valid (f_valid),
    .o_data  (f_data)
  );

  ove_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (f_valid),
    .i_data  (f_data),
    .o_valid (s_valid),
    .o_data  (s_data)
  );

  ove_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (s_valid),
    .i_data  (s_data),
    .o_valid (b_valid),
    .o_data  (b_data)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= b_valid;
    end else if (b_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || pop) begin
      out_data_r <= b_data;
    end else begin
      skid_data_r <= b_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output transaction");

  a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_stall) |=> skid_valid_r)
    else $error("skid entry lost while output stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved to output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_valid_r))
    else $error("output not empty after reset");
`endif

endmodule
